// ===== design/fsli_pkg.sv =====
// Shared constants and types for the first-seen label indexer.
`default_nettype none
package fsli_pkg;

   // Default table depth
   localparam int unsigned MAX_LABELS_DEFAULT = 64;

   // Field widths
   localparam int unsigned LABEL_W    = 32;
   localparam int unsigned INDEX_W    = 7;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned RSP_USER_W = 2;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

endpackage
`default_nettype wire

// ===== design/first_seen_label_indexer_unit.sv =====
// Top level of the first-seen label indexer: table memory, scan sequencer and result register.
//
// Usage: each req transaction carries one 32-bit signed class label in req_tdata and a
// start-of-set flag in req_tuser. The block answers every transaction with exactly one
// rsp transaction carrying the label's 1-based position in the table of distinct labels
// (in order of first appearance), the running distinct count, and the new/overflow flags.
// Flow: after acceptance the label is compared with the stored entries in order, at most
// MAX_LABELS of them (the scan stops at a match); the result register then loads, and the next
// transaction is accepted once that result has been committed.
// The labels live in one synchronous single-port-read table memory that is read one entry
// per cycle; that sequential compare sets the rate. One item is in work at a time.
// A start-of-set flag empties the table before its own label is handled.
// Reset clears the entry count, the sequencer and the result valid; table contents are
// never cleared, since only entries below the count are ever compared.
// When the receiver stalls, the finished result holds in the output register and the
// block still accepts the next item; that item waits at its result step until the
// register is taken.
`default_nettype none
module first_seen_label_indexer_unit #(
   parameter int unsigned MAX_LABELS = fsli_pkg::MAX_LABELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [fsli_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] label
   input  wire logic [fsli_pkg::REQ_USER_W-1:0] req_tuser,  // [0] start_of_set
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [fsli_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [6:0] new_index,
                                                            // [13:7] distinct_count,
                                                            // [15:14] zero
   output logic [fsli_pkg::RSP_USER_W-1:0]      rsp_tuser   // [0] is_new, [1] overflow
);
   import fsli_pkg::*;

   localparam int unsigned AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
   localparam int unsigned CW = $clog2(MAX_LABELS + 1);

   // Label table
   logic [LABEL_W-1:0] table_mem [MAX_LABELS];
   logic [LABEL_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;

   // Control and payload registers
   state_type          state_ff, state_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic               hit_ff, hit_in;
   logic [CW-1:0]      hit_idx_ff, hit_idx_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic          req_accept;
   logic          out_free;
   logic [CW-1:0] start_count;
   logic          scan_hit;
   logic          scan_last;
   logic [CW-1:0] ptr_next;
   logic          room;
   logic [CW-1:0] res_idx;
   logic [CW-1:0] res_count;
   logic          res_new;
   logic          res_ovf;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign start_count = req_tuser[0] ? '0 : count_ff;
   assign ptr_next    = CW'(ptr_ff) + CW'(1);
   assign scan_hit    = (state_ff == ST_SCAN) && (rd_data_ff == label_ff);
   assign scan_last   = (ptr_next == count_ff);
   assign room        = (count_ff < CW'(MAX_LABELS));

   // Issue the next table read: entry 0 on accept, then one entry per scan cycle
   assign rd_en   = req_accept || ((state_ff == ST_SCAN) && !scan_hit && !scan_last);
   assign rd_addr = req_accept ? '0 : AW'(ptr_next);

   // Append an unseen label, if there is room, when the result is committed
   assign wr_en   = (state_ff == ST_RESULT) && out_free && !hit_ff && room;
   assign wr_addr = AW'(count_ff);

   // Form the result of the finished scan
   always_comb begin
      res_new   = !hit_ff;
      res_ovf   = !hit_ff && !room;
      res_count = count_ff;
      res_idx   = hit_idx_ff;
      if (!hit_ff) begin
         if (room) begin
            res_count = count_ff + CW'(1);
            res_idx   = count_ff + CW'(1);
         end else begin
            res_idx = '0;
         end
      end
   end

   // Sequence accept, scan and result
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      label_in      = label_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               label_in = req_tdata[LABEL_W-1:0];
               count_in = start_count;
               ptr_in   = '0;
               hit_in   = 1'b0;
               state_in = (start_count == '0) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = ptr_next;
               state_in   = ST_RESULT;
            end else if (scan_last) begin
               state_in = ST_RESULT;
            end else begin
               ptr_in = AW'(ptr_next);
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               count_in      = res_count;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, INDEX_W'(res_count), INDEX_W'(res_idx)};
               rsp_tuser_in  = {res_ovf, res_new};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      label_ff     <= label_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Table memory: registered read, single write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
      if (wr_en) begin
         table_mem[wr_addr] <= label_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // Count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LABELS))
      else $error("entry count beyond table depth");

   // Overflow only on an unseen label, with index zero
   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tuser[0] && (rsp_tdata[INDEX_W-1:0] == '0)))
      else $error("overflow result malformed");

   // A known label maps inside the current count
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         ((rsp_tdata[INDEX_W-1:0] != '0) &&
          (rsp_tdata[INDEX_W-1:0] <= rsp_tdata[2*INDEX_W-1:INDEX_W])))
      else $error("hit index outside table");

   // An accepted item leaves the idle state
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input taken twice in a row");

   // Table writes happen only when a result is committed
   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1])
      else $error("table write without a new-label result");
`endif

endmodule
`default_nettype wire

// ===== dv/first_seen_label_indexer_unit_tb.sv =====
// Testbench for the first-seen label indexer: directed and random label sets checked
// against a cycle-free model of the relabeling table.
`timescale 1ns / 100ps
module first_seen_label_indexer_unit_tb;
   import fsli_pkg::*;

   localparam int unsigned TABLE_DEPTH = MAX_LABELS_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned IDLE_PERCENT = 36;
   // Accepted-transaction window in which neither side idles
   localparam int unsigned CALM_FROM = 500;
   localparam int unsigned CALM_TO = 700;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               start_of_set;
   } label_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] new_index;
      logic               is_new;
      logic [INDEX_W-1:0] distinct_count;
      logic               overflow;
   } rank_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] label
   logic [REQ_USER_W-1:0] req_tuser = '0;   // [0] start_of_set
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [6:0] new_index, [13:7] distinct_count, [15:14] zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] is_new, [1] overflow

   label_item_type  pending_labels[$];
   rank_result_type predicted_ranks[$];

   // Model of the first-appearance table
   logic [LABEL_W-1:0] first_seen_table[TABLE_DEPTH];
   int unsigned        table_fill = 0;

   bit          req_taken = 1'b0;
   int unsigned accepted_count = 0;
   int unsigned result_count = 0;
   int unsigned new_count = 0;
   int unsigned overflow_count = 0;
   int unsigned set_count = 0;
   int unsigned peak_fill = 0;
   int unsigned error_count = 0;

   first_seen_label_indexer_unit #(
      .MAX_LABELS(TABLE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Clock and the single reset pulse
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Look the label up in order of first appearance; append it if unseen and there is room
   function automatic rank_result_type rank_label(logic [LABEL_W-1:0] lab, logic clear);
      rank_result_type r;
      int unsigned     pos;
      bit              hit;
      r = '0;
      hit = 1'b0;
      if (clear) table_fill = 0;
      for (pos = 0; pos < table_fill && !hit; pos++) begin
         if (first_seen_table[pos] == lab) begin
            hit = 1'b1;
            r.new_index = INDEX_W'(pos + 1);
         end
      end
      if (!hit) begin
         r.is_new = 1'b1;
         if (table_fill < TABLE_DEPTH) begin
            first_seen_table[table_fill] = lab;
            table_fill++;
            r.new_index = INDEX_W'(table_fill);
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.distinct_count = INDEX_W'(table_fill);
      return r;
   endfunction

   function automatic bit calm_phase();
      return accepted_count >= CALM_FROM && accepted_count < CALM_TO;
   endfunction

   // Mostly full-range labels, some clustered just above zero, just below zero and at the most negative value
   function automatic logic [LABEL_W-1:0] random_label();
      case ($urandom_range(9, 0))
         0: return LABEL_W'($urandom_range(15, 0));
         1: return 32'h8000_0000 | LABEL_W'($urandom_range(15, 0));
         2: return 32'hFFFF_FFFF - LABEL_W'($urandom_range(15, 0));
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      error_count++;
      if (error_count <= 40)
         $display("MISMATCH at %0t: result %0d %s got %0d want %0d",
                  $realtime, result_count, what, got, want);
   endtask

   task automatic push_label(logic [LABEL_W-1:0] lab, logic sos);
      label_item_type it;
      it.label = lab;
      it.start_of_set = sos;
      pending_labels = {pending_labels, it};
   endtask

   // Build a set from a pool of distinct labels: each step either introduces the next
   // pool entry or repeats one already introduced
   task automatic add_label_set(int unsigned pool_size, int unsigned length, bit open_set);
      logic [LABEL_W-1:0] pool[$];
      logic [LABEL_W-1:0] v;
      bit                 dup;
      int unsigned        next;
      int unsigned        n;
      while (pool.size() < pool_size) begin
         v = random_label();
         dup = 1'b0;
         foreach (pool[k]) if (pool[k] == v) dup = 1'b1;
         if (!dup) pool = {pool, v};
      end
      next = 0;
      for (n = 0; n < length; n++) begin
         if (next < pool_size && (next == 0 || $urandom_range(3, 0) != 0)) begin
            v = pool[next];
            next++;
         end else begin
            v = pool[$urandom_range(next - 1, 0)];
         end
         push_label(v, open_set && n == 0);
      end
   endtask

   // Stimulus: directed corners, then random sets, then drain
   initial begin
      int unsigned budget;
      int unsigned pool_size;
      int unsigned length;
      int unsigned pick;

      // Extremes, seen and unseen labels, clears mid-stream
      push_label(32'h0000_0000, 1'b1);
      push_label(32'h0000_0000, 1'b0);
      push_label(32'h7FFF_FFFF, 1'b0);
      push_label(32'h8000_0000, 1'b0);
      push_label(32'hFFFF_FFFF, 1'b0);
      push_label(32'h0000_0001, 1'b0);
      push_label(32'h8000_0000, 1'b0);
      push_label(32'hFFFF_FFFE, 1'b0);
      push_label(32'h7FFF_FFFF, 1'b0);
      push_label(32'h7FFF_FFFF, 1'b1);
      push_label(32'h0000_0000, 1'b0);
      push_label(32'h7FFF_FFFF, 1'b1);
      push_label(32'hAAAA_AAAA, 1'b1);
      push_label(32'h5555_5555, 1'b0);
      push_label(32'hAAAA_AAAA, 1'b0);
      push_label(32'h5555_5555, 1'b0);

      // Random label sets; a few fill the table exactly or run past it
      budget = RANDOM_ITEMS;
      while (budget > 0) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            push_label($urandom, 1'($urandom));
            length = 1;
         end else begin
            if (pick < 48) pool_size = $urandom_range(8, 1);
            else if (pick < 76) pool_size = $urandom_range(40, 9);
            else if (pick < 88) pool_size = $urandom_range(TABLE_DEPTH, TABLE_DEPTH - 4);
            else pool_size = $urandom_range(TABLE_DEPTH + 16, TABLE_DEPTH + 1);
            length = pool_size * 3 / 2 + $urandom_range(pool_size + 8, 2);
            // Trim the last set to the remaining budget
            if (length > budget) length = budget;
            add_label_set(pool_size, length, $urandom_range(9, 0) != 0);
         end
         budget = (length >= budget) ? 0 : budget - length;
      end

      while (pending_labels.size() != 0 || predicted_ranks.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("Relabeled %0d labels over %0d set starts: %0d new, %0d overflow, peak fill %0d.",
               result_count, set_count, new_count, overflow_count, peak_fill);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Record each accepted request transaction and predict its result
   always @(posedge clock) begin
      label_item_type  it;
      rank_result_type r;
      if (!reset && req_tvalid && req_tready) begin
         it = pending_labels.pop_front();
         r = rank_label(it.label, it.start_of_set);
         predicted_ranks = {predicted_ranks, r};
         if (it.start_of_set) set_count++;
         if (table_fill > peak_fill) peak_fill = table_fill;
         req_taken = 1'b1;
         accepted_count++;
      end
   end

   // Drive the next label and the receiver stall on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_labels.size() != 0 &&
                (calm_phase() || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_labels[0].label;
               req_tuser <= pending_labels[0].start_of_set;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         req_taken = 1'b0;
         rsp_tready <= calm_phase() || $urandom_range(99, 0) >= IDLE_PERCENT;
      end
   end

   // Compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin
      rank_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_ranks.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = predicted_ranks.pop_front();
            if (rsp_tdata[6:0] !== want.new_index)
               report_mismatch("new_index", rsp_tdata[6:0], want.new_index);
            if (rsp_tdata[13:7] !== want.distinct_count)
               report_mismatch("distinct_count", rsp_tdata[13:7], want.distinct_count);
            if (rsp_tdata[15:14] !== 2'b00)
               report_mismatch("padding", rsp_tdata[15:14], 0);
            if (rsp_tuser[0] !== want.is_new)
               report_mismatch("is_new", rsp_tuser[0], want.is_new);
            if (rsp_tuser[1] !== want.overflow)
               report_mismatch("overflow", rsp_tuser[1], want.overflow);
            if (want.is_new) new_count++;
            if (want.overflow) overflow_count++;
         end
         result_count++;
      end
   end

   // Hard stop well past the slowest legal run
   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/fsli_pkg.sv
design/first_seen_label_indexer_unit.sv
dv/first_seen_label_indexer_unit_tb.sv
